// ===== rtl/ilrp_pkg.sv =====
// shared types, codes and helpers for the ini line record parser
package ilrp_pkg;

  localparam int LINE_CAP_DEF    = 128;
  localparam int SECTION_CAP_DEF = 16;
  localparam int KEY_CAP_DEF     = 16;
  localparam int VALUE_CAP_DEF   = 32;

  // widths sized for the largest allowed caps
  localparam int PW  = 8;  // line position / length
  localparam int SLW = 4;  // section length
  localparam int KLW = 4;  // key length
  localparam int VLW = 6;  // value length
  localparam int CW  = 6;  // back end character counter

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_HALT = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] PART_SEC = 2'd0;
  localparam logic [1:0] PART_KEY = 2'd1;
  localparam logic [1:0] PART_VAL = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SEC  = 2'd1;
  localparam logic [1:0] KIND_REC  = 2'd2;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_LB   = 8'h5B;
  localparam logic [7:0] CH_RB   = 8'h5D;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] part;
    logic       char_valid;
    logic [7:0] char_value;
    logic       record_last;
  } out_word_t;

  // one finished line, classified by the front end
  typedef struct packed {
    logic           bank;
    logic [1:0]     kind;
    logic           clear;
    logic [PW-1:0]  sec_start;
    logic [SLW-1:0] sec_len;
    logic [PW-1:0]  key_pos;
    logic [KLW-1:0] key_len;
    logic [PW-1:0]  val_pos;
    logic [VLW-1:0] val_len;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_trailing(input logic [7:0] c);
    is_trailing = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// ===== rtl/ini_line_record_parser.sv =====
// top level of the ini line record parser: front end, line queue, back end
//
// usage
// - input channel (push/full, item): one word per accepted edge; op selects a
//   text byte, end of buffer or consumer halt
// - result channel (empty/pop, result): one character word per edge; a record
//   is its section chars, key chars, value chars, record_last on the final one
// - a record starts once its newline word queues the line; section chars
//   come from the section store, each key or value char via a read and an
//   emit state (registered read of the line bank before the output register)
// - throughput: 1 text word per cycle while a free line bank is open; two
//   banks alternate, so full rises only when a line ends while the back end
//   still holds the other bank
// - in the back end a section line costs a read and a write state per stored byte
// - reset: synchronous, clears bank flags, queue, section, halt and output valid
// - stall: holding pop low freezes a valid output word and the record stream;
//   the front end keeps filling the open bank until its next line end
module ini_line_record_parser #(
  parameter int LINE_CAP    = ilrp_pkg::LINE_CAP_DEF,
  parameter int SECTION_CAP = ilrp_pkg::SECTION_CAP_DEF,
  parameter int KEY_CAP     = ilrp_pkg::KEY_CAP_DEF,
  parameter int VALUE_CAP   = ilrp_pkg::VALUE_CAP_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ilrp_pkg::in_word_t  item,
  input  logic                pop,
  output logic                empty,
  output ilrp_pkg::out_word_t result
);
  import ilrp_pkg::*;

  // line bank address: bank bit on top of the byte index
  localparam int AW = $clog2(LINE_CAP - 1);

  logic        ram_we;
  logic [AW:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [AW:0] ram_raddr;
  logic [7:0]  ram_rdata;

  // finished lines travel through a short queue
  logic  desc_push;
  desc_t desc_word;
  logic  desc_full;
  logic  desc_pop;
  desc_t desc_head;
  logic  desc_empty;
  rel_t  rel;

  ilrp_front #(
    .LINE_CAP    (LINE_CAP),
    .SECTION_CAP (SECTION_CAP),
    .KEY_CAP     (KEY_CAP),
    .VALUE_CAP   (VALUE_CAP),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .desc_push (desc_push),
    .desc_word (desc_word),
    .rel       (rel)
  );

  // two line banks in one memory
  ilrp_ram #(
    .WIDTH (8),
    .DEPTH (2 << AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ilrp_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .wdata (desc_word),
    .full  (desc_full),
    .pop   (desc_pop),
    .rdata (desc_head),
    .empty (desc_empty)
  );

  // back end owns the current section and the output word register
  ilrp_back #(
    .SECTION_CAP (SECTION_CAP),
    .AW          (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .desc_word  (desc_head),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel        (rel),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

`ifndef SYNTHESIS
  // one queue slot per bank, so a finished line always finds room
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !desc_full)
    else $error("line queue overflow");

  // a bank is never handed back in the cycle it is handed over
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (desc_push && rel.valid) |-> (desc_word.bank != rel.bank))
    else $error("line bank pushed and released together");

  // the back end takes a descriptor only while the queue holds one
  a_read_queued: assert property (@(posedge clk) disable iff (rst)
    desc_pop |-> !desc_empty)
    else $error("descriptor taken from empty queue");
`endif

endmodule

// ===== rtl/ilrp_ram.sv =====
// generic one write, one read ram with registered read data
module ilrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/ilrp_fifo.sv =====
// two entry queue of line descriptors between front and back end
module ilrp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ilrp_pkg::desc_t wdata,
  output logic           full,
  input  logic           pop,
  output ilrp_pkg::desc_t rdata,
  output logic           empty
);
  import ilrp_pkg::*;

  desc_t     slots [2];
  logic      wptr;
  logic      rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule

// ===== rtl/ilrp_front.sv =====
// front end: takes text words, fills the line banks and classifies each line
module ilrp_front #(
  parameter int LINE_CAP    = ilrp_pkg::LINE_CAP_DEF,
  parameter int SECTION_CAP = ilrp_pkg::SECTION_CAP_DEF,
  parameter int KEY_CAP     = ilrp_pkg::KEY_CAP_DEF,
  parameter int VALUE_CAP   = ilrp_pkg::VALUE_CAP_DEF,
  parameter int AW          = $clog2(LINE_CAP - 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ilrp_pkg::in_word_t item,
  output logic               ram_we,
  output logic [AW:0]        ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic               desc_push,
  output ilrp_pkg::desc_t    desc_word,
  input  ilrp_pkg::rel_t     rel
);
  import ilrp_pkg::*;

  logic          wbank;
  logic [1:0]    bank_busy;
  logic          halted;
  logic [PW-1:0] len;
  logic          seen_nb;
  logic [PW-1:0] p;
  logic [7:0]    first;
  logic          eq_found;
  logic          kh;
  logic [PW-1:0] klast;
  logic          vseen;
  logic [PW-1:0] vs;
  logic          vh;
  logic [PW-1:0] vlast;
  logic          rb_found;
  logic [PW-1:0] q;

  logic          acc;
  logic          is_byte;
  logic          term;
  logic          store;
  logic          op_end;
  logic [7:0]    b;
  logic          nb_now;
  logic [PW-1:0] p_eff;
  logic          vnew;
  logic [PW-1:0] vs_eff;
  logic          kwin;
  logic          vwin;
  logic [PW-1:0] sec_d;

  assign b       = item.byte_value;
  assign full    = bank_busy[wbank];
  assign acc     = push && !full;
  assign is_byte = acc && (item.op == OP_BYTE) && !halted;
  assign term    = is_byte && ((b == CH_LF) || (b == CH_NUL));
  assign store   = is_byte && !term && (len < PW'(LINE_CAP - 1));
  assign op_end  = acc && (item.op == OP_END);

  assign nb_now = !seen_nb && !is_blank(b);
  assign p_eff  = seen_nb ? p : len;
  assign vnew   = eq_found && !vseen && !is_blank(b);
  assign vs_eff = vseen ? vs : len;
  assign kwin   = {1'b0, len} < ({1'b0, p_eff} + (PW + 1)'(KEY_CAP - 1));
  assign vwin   = {1'b0, len} < ({1'b0, vs_eff} + (PW + 1)'(VALUE_CAP - 1));

  assign ram_we    = store;
  assign ram_waddr = {wbank, len[AW-1:0]};
  assign ram_wdata = b;

  assign desc_push = term || op_end;
  assign sec_d     = q - p - PW'(1);

  always_comb begin
    desc_word           = '0;
    desc_word.bank      = wbank;
    desc_word.clear     = op_end;
    desc_word.sec_start = p + PW'(1);
    desc_word.sec_len   = (sec_d > PW'(SECTION_CAP - 1)) ? SLW'(SECTION_CAP - 1)
                                                         : sec_d[SLW-1:0];
    desc_word.key_pos   = p;
    desc_word.key_len   = kh ? KLW'(klast - p + PW'(1)) : '0;
    desc_word.val_pos   = vs;
    desc_word.val_len   = vh ? VLW'(vlast - vs + PW'(1)) : '0;
    if (halted || !seen_nb || (first == CH_HASH) || (first == CH_SEMI)) begin
      desc_word.kind = KIND_NONE;
    end else if (first == CH_LB) begin
      desc_word.kind = rb_found ? KIND_SEC : KIND_NONE;
    end else if (eq_found) begin
      desc_word.kind = KIND_REC;
    end else begin
      desc_word.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      if (nb_now) begin
        p     <= len;
        first <= b;
      end
      if (!eq_found && (b != CH_EQ) && (seen_nb || nb_now) && kwin && !is_trailing(b)) begin
        klast <= len;
      end
      if (vnew) begin
        vs <= len;
      end
      if (eq_found && (vseen || vnew) && vwin && !is_trailing(b)) begin
        vlast <= len;
      end
      if (seen_nb && (first == CH_LB) && !rb_found && (b == CH_RB)) begin
        q <= len;
      end
    end
    if (rst) begin
      wbank     <= 1'b0;
      bank_busy <= 2'b00;
      halted    <= 1'b0;
      len       <= '0;
      seen_nb   <= 1'b0;
      eq_found  <= 1'b0;
      kh        <= 1'b0;
      vseen     <= 1'b0;
      vh        <= 1'b0;
      rb_found  <= 1'b0;
    end else begin
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
      if (desc_push) begin
        bank_busy[wbank] <= 1'b1;
        wbank            <= ~wbank;
      end
      if (acc && (item.op == OP_HALT)) begin
        halted <= 1'b1;
      end
      if (op_end) begin
        halted <= 1'b0;
      end
      if (desc_push) begin
        len      <= '0;
        seen_nb  <= 1'b0;
        eq_found <= 1'b0;
        kh       <= 1'b0;
        vseen    <= 1'b0;
        vh       <= 1'b0;
        rb_found <= 1'b0;
      end else if (store) begin
        len <= len + PW'(1);
        if (nb_now) begin
          seen_nb <= 1'b1;
        end
        if (!eq_found && (b == CH_EQ)) begin
          eq_found <= 1'b1;
        end
        if (!eq_found && (b != CH_EQ) && (seen_nb || nb_now) && kwin && !is_trailing(b)) begin
          kh <= 1'b1;
        end
        if (vnew) begin
          vseen <= 1'b1;
        end
        if (eq_found && (vseen || vnew) && vwin && !is_trailing(b)) begin
          vh <= 1'b1;
        end
        if (seen_nb && (first == CH_LB) && !rb_found && (b == CH_RB)) begin
          rb_found <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/ilrp_back.sv =====
// back end: copies sections and streams records out of the line banks
module ilrp_back #(
  parameter int SECTION_CAP = ilrp_pkg::SECTION_CAP_DEF,
  parameter int AW          = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_empty,
  output logic                desc_pop,
  input  ilrp_pkg::desc_t     desc_word,
  output logic                ram_re,
  output logic [AW:0]         ram_raddr,
  input  logic [7:0]          ram_rdata,
  output ilrp_pkg::rel_t      rel,
  output logic                empty,
  input  logic                pop,
  output ilrp_pkg::out_word_t result
);
  import ilrp_pkg::*;

  localparam int SD  = SECTION_CAP - 1;
  localparam int SIW = (SD > 1) ? $clog2(SD) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SRD  = 8'b00000010,
    S_SWR  = 8'b00000100,
    S_RSEC = 8'b00001000,
    S_KRD  = 8'b00010000,
    S_KEM  = 8'b00100000,
    S_VRD  = 8'b01000000,
    S_VEM  = 8'b10000000
  } state_t;

  state_t         state;
  desc_t          cur;
  logic [CW-1:0]  cnt;
  logic [7:0]     sec_store [SD];
  logic [SLW-1:0] section_length;
  logic           out_valid;

  logic           slot;
  logic           emit;
  out_word_t      emit_word;
  logic           fin;
  logic           fin_clear;
  logic [PW-1:0]  base;
  logic [PW-1:0]  rd_pos;
  logic           sec_last;
  logic           key_last;
  logic           val_last;
  logic           copy_last;

  assign slot      = !out_valid || pop;
  assign empty     = !out_valid;
  assign desc_pop  = (state == S_IDLE) && !desc_empty;
  assign sec_last  = (section_length == SLW'(0)) || ((cnt + CW'(1)) == CW'(section_length));
  assign key_last  = (cnt + CW'(1)) == CW'(cur.key_len);
  assign val_last  = (cnt + CW'(1)) == CW'(cur.val_len);
  assign copy_last = (cnt + CW'(1)) == CW'(cur.sec_len);

  always_comb begin
    case (state)
      S_SRD:   base = cur.sec_start;
      S_KRD:   base = cur.key_pos;
      default: base = cur.val_pos;
    endcase
  end
  assign rd_pos    = base + PW'(cnt);
  assign ram_raddr = {cur.bank, rd_pos[AW-1:0]};
  assign ram_re    = (state == S_SRD) || ((state == S_KRD) && (cur.key_len != '0))
                  || ((state == S_VRD) && (cur.val_len != '0));

  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    fin       = 1'b0;
    case (state)
      S_IDLE: begin
        fin = !desc_empty && (desc_word.kind != KIND_REC)
           && ((desc_word.kind != KIND_SEC) || (desc_word.sec_len == '0));
      end
      S_SWR: begin
        fin = copy_last;
      end
      S_RSEC: begin
        emit                 = slot;
        emit_word.part       = PART_SEC;
        emit_word.char_valid = (section_length != '0);
        emit_word.char_value = (section_length != '0) ? sec_store[cnt[SIW-1:0]] : 8'h00;
      end
      S_KRD: begin
        emit           = slot && (cur.key_len == '0);
        emit_word.part = PART_KEY;
      end
      S_KEM: begin
        emit                 = slot;
        emit_word.part       = PART_KEY;
        emit_word.char_valid = 1'b1;
        emit_word.char_value = ram_rdata;
      end
      S_VRD: begin
        emit                  = slot && (cur.val_len == '0);
        emit_word.part        = PART_VAL;
        emit_word.record_last = 1'b1;
        fin                   = emit;
      end
      S_VEM: begin
        emit                  = slot;
        emit_word.part        = PART_VAL;
        emit_word.char_valid  = 1'b1;
        emit_word.char_value  = ram_rdata;
        emit_word.record_last = val_last;
        fin                   = slot && val_last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign fin_clear = (state == S_IDLE) ? desc_word.clear : cur.clear;
  assign rel.valid = fin;
  assign rel.bank  = (state == S_IDLE) ? desc_word.bank : cur.bank;

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_word;
    end
    if ((state == S_SWR) && (cnt < CW'(SD))) begin
      sec_store[cnt[SIW-1:0]] <= ram_rdata;
    end
    if (desc_pop) begin
      cur <= desc_word;
    end
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      section_length <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (!desc_empty) begin
            if (desc_word.kind == KIND_SEC) begin
              if (desc_word.sec_len == '0) begin
                section_length <= '0;
              end else begin
                state <= S_SRD;
              end
            end else if (desc_word.kind == KIND_REC) begin
              state <= S_RSEC;
            end
          end
        end
        S_SRD: begin
          state <= S_SWR;
        end
        S_SWR: begin
          if (copy_last) begin
            section_length <= cur.sec_len;
            state          <= S_IDLE;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_SRD;
          end
        end
        S_RSEC: begin
          if (slot) begin
            if (sec_last) begin
              cnt   <= '0;
              state <= S_KRD;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        S_KRD: begin
          if (cur.key_len != '0) begin
            state <= S_KEM;
          end else if (slot) begin
            cnt   <= '0;
            state <= S_VRD;
          end
        end
        S_KEM: begin
          if (slot) begin
            if (key_last) begin
              cnt   <= '0;
              state <= S_VRD;
            end else begin
              cnt   <= cnt + CW'(1);
              state <= S_KRD;
            end
          end
        end
        S_VRD: begin
          if (cur.val_len != '0) begin
            state <= S_VEM;
          end else if (slot) begin
            state <= S_IDLE;
          end
        end
        S_VEM: begin
          if (slot) begin
            if (val_last) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + CW'(1);
              state <= S_VRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin && fin_clear) begin
        section_length <= '0;
      end
    end
  end
endmodule

// ===== verif/ilrp_checker.sv =====
// checker for the ini line record parser: watches both channels, predicts records, compares
module ilrp_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  ilrp_pkg::in_word_t  item,
  input  logic                pop,
  input  logic                empty,
  input  ilrp_pkg::out_word_t result,
  output int                  fail_count,
  output int                  pending,
  output int                  records_seen
);
  import ilrp_pkg::*;

  localparam int LCAP = LINE_CAP_DEF - 1;
  localparam int SCAP = SECTION_CAP_DEF - 1;
  localparam int KCAP = KEY_CAP_DEF - 1;
  localparam int VCAP = VALUE_CAP_DEF - 1;

  logic [7:0] line_buf [LCAP];
  int         line_len;
  logic [7:0] sec_buf [SCAP];
  int         sec_len;
  logic       stopped;
  out_word_t  expected_chars [$];

  function automatic logic blank_ch(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic trail_ch(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  task automatic add_char(logic [1:0] part, logic vld, logic [7:0] ch);
    out_word_t w;
    w.part = part;
    w.char_valid = vld;
    w.char_value = vld ? ch : 8'h00;
    w.record_last = 1'b0;
    expected_chars.push_back(w);
  endtask

  // strip leading blanks, truncate, trim trailing white space
  task automatic cut(int start, int stop, int cap, output int from, output int len);
    while (start < stop && blank_ch(line_buf[start])) start++;
    len = stop - start;
    if (len > cap) len = cap;
    while (len > 0 && trail_ch(line_buf[start + len - 1])) len--;
    from = start;
  endtask

  task automatic close_line();
    int p, q, eq, ks, kl, vs, vl;
    logic [7:0] c;
    out_word_t w;
    p = 0;
    while (p < line_len && blank_ch(line_buf[p])) p++;
    if (p >= line_len) return;
    c = line_buf[p];
    if (c == CH_HASH || c == CH_SEMI) return;
    if (c == CH_LB) begin
      p++;
      q = p;
      while (q < line_len && line_buf[q] != CH_RB) q++;
      if (q >= line_len) return;
      q -= p;
      if (q > SCAP) q = SCAP;
      for (int i = 0; i < q; i++) sec_buf[i] = line_buf[p + i];
      sec_len = q;
      return;
    end
    eq = 0;
    while (eq < line_len && line_buf[eq] != CH_EQ) eq++;
    if (eq >= line_len) return;
    cut(0, eq, KCAP, ks, kl);
    cut(eq + 1, line_len, VCAP, vs, vl);
    if (sec_len == 0) add_char(PART_SEC, 1'b0, 8'h00);
    for (int i = 0; i < sec_len; i++) add_char(PART_SEC, 1'b1, sec_buf[i]);
    if (kl == 0) add_char(PART_KEY, 1'b0, 8'h00);
    for (int i = 0; i < kl; i++) add_char(PART_KEY, 1'b1, line_buf[ks + i]);
    if (vl == 0) add_char(PART_VAL, 1'b0, 8'h00);
    for (int i = 0; i < vl; i++) add_char(PART_VAL, 1'b1, line_buf[vs + i]);
    w = expected_chars.pop_back();
    w.record_last = 1'b1;
    expected_chars.push_back(w);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      line_len = 0;
      sec_len = 0;
      stopped = 1'b0;
      fail_count <= 0;
      records_seen <= 0;
      pending <= 0;
    end else begin
      // result side first: a newly predicted record never matches this edge's word
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (result.record_last) records_seen <= records_seen + 1;
          if (result !== want) begin
            $display("%0t: expected %h actual %h", $time, want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) begin
        case (item.op)
          OP_BYTE: begin
            if (!stopped) begin
              if (item.byte_value == CH_LF || item.byte_value == CH_NUL) begin
                close_line();
                line_len = 0;
              end else if (line_len < LCAP) begin
                line_buf[line_len] = item.byte_value;
                line_len = line_len + 1;
              end
            end
          end
          OP_END: begin
            if (!stopped) close_line();
            line_len = 0;
            sec_len = 0;
            stopped = 1'b0;
          end
          OP_HALT: stopped = 1'b1;
          default: ;
        endcase
      end
      pending <= expected_chars.size();
    end
  end
endmodule

// ===== verif/tb_ini_line_record_parser.sv =====
// testbench top for the ini line record parser: stimulus, stalls and verdict
module tb_ini_line_record_parser;
  import ilrp_pkg::*;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_word_t  item;
  logic      pop;
  logic      empty;
  out_word_t result;
  int        fail_count;
  int        pending;
  int        records_seen;
  int        words_sent;
  logic      hold_off;

  ini_line_record_parser u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result)
  );

  ilrp_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .fail_count(fail_count), .pending(pending), .records_seen(records_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue of words still to offer
  in_word_t text_q [$];
  int       burst_left;
  int       gap_left;

  function automatic in_word_t mk(logic [1:0] op, logic [7:0] b);
    in_word_t w;
    w.op = op;
    w.byte_value = b;
    return w;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(mk(OP_BYTE, s[i]));
  endtask

  // random printable-ish byte, sometimes white space or a byte from the upper half
  function automatic logic [7:0] rnd_char();
    case ($urandom_range(0, 9))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_CR;
      3: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  task automatic add_rnd(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = rnd_char();
      if (c == CH_EQ || c == CH_RB || c == CH_LB) c = 8'h61;
      text_q.push_back(mk(OP_BYTE, c));
    end
  endtask

  // a well formed line with random content, ended by newline or nul
  task automatic add_rnd_line();
    case ($urandom_range(0, 9))
      0, 1: begin
        text_q.push_back(mk(OP_BYTE, CH_LB));
        add_rnd($urandom_range(0, 18));
        text_q.push_back(mk(OP_BYTE, CH_RB));
      end
      2: begin
        text_q.push_back(mk(OP_BYTE, $urandom_range(0, 1) ? CH_HASH : CH_SEMI));
        add_rnd($urandom_range(0, 6));
      end
      3: add_rnd($urandom_range(0, 5));
      4: text_q.push_back(mk(OP_BYTE, 8'($urandom)));
      default: begin
        add_rnd($urandom_range(0, $urandom_range(0, 1) ? 4 : 18));
        text_q.push_back(mk(OP_BYTE, CH_EQ));
        add_rnd($urandom_range(0, $urandom_range(0, 1) ? 4 : 34));
      end
    endcase
    text_q.push_back(mk(OP_BYTE, $urandom_range(0, 3) ? CH_LF : CH_NUL));
  endtask

  // sender: bursts with gaps, one nonblocking assignment per signal per edge
  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part: sections, comments, trimming, halt, end of buffer
    add_text("[core]\n");
    add_text(" k\t= v \r\n");
    add_text("#c\n;c\n\t\n");
    add_text("[op\nno\n");
    add_text("=\n");
    add_text("x=y");
    text_q.push_back(mk(OP_BYTE, CH_NUL));
    text_q.push_back(mk(OP_BYTE, 8'hff));
    add_text("a=1");
    text_q.push_back(mk(OP_END, 8'hff));
    add_text("b=2\n");
    text_q.push_back(mk(OP_HALT, 8'h00));
    add_text("c=3\n");
    text_q.push_back(mk(OP_RSVD, 8'h5a));
    text_q.push_back(mk(OP_END, 8'h00));
    text_q.push_back(mk(OP_HALT, 8'h00));
    text_q.push_back(mk(OP_END, 8'h00));

    // random part: mostly well formed lines, some halts and stray ops
    while (text_q.size() < 118) begin
      case ($urandom_range(0, 19))
        0: text_q.push_back(mk(OP_HALT, 8'($urandom)));
        1: text_q.push_back(mk(OP_END, 8'($urandom)));
        2: text_q.push_back(mk(OP_RSVD, 8'($urandom)));
        default: add_rnd_line();
      endcase
    end
    add_text("z=end");
    text_q.push_back(mk(OP_END, 8'h00));

    burst_left = 0;
    gap_left = 0;
    while (text_q.size() != 0) begin
      if (gap_left > 0) begin
        push <= 1'b0;
        gap_left--;
        @(posedge clk);
      end else begin
        push <= 1'b1;
        item <= text_q[0];
        @(posedge clk);
        if (!full) begin
          void'(text_q.pop_front());
          words_sent++;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
          end
        end
      end
    end
    push <= 1'b0;

    // drain, then wait for anything late
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d input words, checked %0d records", words_sent, records_seen);
    $display("covered sections, comments, trimming, field caps, halt and end of buffer");
    if (fail_count == 0 && pending == 0) begin
      $display("ini_line_record_parser: match");
    end else begin
      $display("ini_line_record_parser: mismatch");
    end
    $finish;
  end

  // long hold-off once so the line banks fill and full rises
  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // receiver: own stall pattern, stretches with no stalls
  initial begin
    int phase;
    pop <= 1'b0;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) pop <= 1'b0;
      else if ((phase / 64) % 3 == 0) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #3000000;
    $display("ini_line_record_parser: mismatch");
    $finish;
  end
endmodule
